// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property wrapper used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising edge, off during reset.
`define VT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, but also checked while reset is high.
`define VT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/vt_pkg.sv -----
// ----------------------------------------------------------------------------
// vt_pkg
// Shared types and constants of the 4x4 vertex transform pipeline.
// ----------------------------------------------------------------------------
package vt_pkg;

   localparam int DATA_W = 32;
   localparam int VEC_N  = 4;
   localparam int ELEM_N = VEC_N * VEC_N;
   localparam int IDX_W  = 4;
   localparam int PROD_W = 2 * DATA_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_XFORM = 1'b1;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [PAIR_W-1:0] pair_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [IDX_W-1:0]         idx_type;

   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;

endpackage

// ----- hdl/vt_matrix.sv -----
// ----------------------------------------------------------------------------
// vt_matrix
// 16-entry column-major matrix store, reset to identity, one write per cycle.
// ----------------------------------------------------------------------------
module vt_matrix #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  vt_pkg::idx_type   wr_index,
   input  vt_pkg::word_type  wr_value,
   output vt_pkg::word_type  mat [vt_pkg::ELEM_N]
);
   import vt_pkg::*;

   word_type mat_ff [ELEM_N];
   word_type mat_in [ELEM_N];

   always_comb begin
      for (int i = 0; i < ELEM_N; i++) begin
         mat_in[i] = mat_ff[i];
      end
      if (wr_en) begin
         mat_in[wr_index] = wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ELEM_N; i++) begin
            // diagonal entries sit at c*4+c
            mat_ff[i] <= (i % (VEC_N + 1) == 0) ? word_type'(1) <<< FRAC_BITS : '0;
         end
      end else begin
         for (int i = 0; i < ELEM_N; i++) begin
            mat_ff[i] <= mat_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ELEM_N; i++) begin
         mat[i] = mat_ff[i];
      end
   end

endmodule

// ----- hdl/vt_mul.sv -----
// ----------------------------------------------------------------------------
// vt_mul
// Vector input register and the 16 element products, one stage each.
// ----------------------------------------------------------------------------
module vt_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  vt_pkg::word_type  vec [vt_pkg::VEC_N],
   input  vt_pkg::word_type  mat [vt_pkg::ELEM_N],
   output logic              out_valid,
   input  logic              out_ready,
   output vt_pkg::prod_type  prod [vt_pkg::ELEM_N]
);
   import vt_pkg::*;

   logic     va_ff, va_in;
   logic     vb_ff, vb_in;
   logic     ready_a, ready_b;
   word_type vec_ff [VEC_N];
   prod_type prod_ff [ELEM_N];

   assign ready_b  = !vb_ff || out_ready;
   assign ready_a  = !va_ff || ready_b;
   assign in_ready = ready_a;
   assign va_in    = ready_a ? in_valid : va_ff;
   assign vb_in    = ready_b ? va_ff : vb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         for (int c = 0; c < VEC_N; c++) begin
            vec_ff[c] <= vec[c];
         end
      end
   end

   // Products read the matrix as the item leaves the input register; a later
   // element write cannot be taken before that edge.
   always_ff @(posedge clock) begin
      if (ready_b && va_ff) begin
         for (int k = 0; k < ELEM_N; k++) begin
            prod_ff[k] <= prod_type'(mat[k]) * prod_type'(vec_ff[k / VEC_N]);
         end
      end
   end

   assign out_valid = vb_ff;

   always_comb begin
      for (int k = 0; k < ELEM_N; k++) begin
         prod[k] = prod_ff[k];
      end
   end

endmodule

// ----- hdl/vt_reduce.sv -----
// ----------------------------------------------------------------------------
// vt_reduce
// Row sums in two adder stages, then floor shift, saturation and result reg.
// ----------------------------------------------------------------------------
module vt_reduce #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  vt_pkg::prod_type  prod [vt_pkg::ELEM_N],
   output logic              out_valid,
   input  logic              out_ready,
   output vt_pkg::word_type  res [vt_pkg::VEC_N],
   output logic              sat
);
   import vt_pkg::*;

   logic     vc_ff, vc_in, vd_ff, vd_in, ve_ff, ve_in;
   logic     ready_c, ready_d, ready_e;
   pair_type pair_ff [2*VEC_N];
   sum_type  sum_ff [VEC_N];
   word_type res_ff [VEC_N];
   word_type res_in [VEC_N];
   logic     sat_ff, sat_in;

   assign ready_e  = !ve_ff || out_ready;
   assign ready_d  = !vd_ff || ready_e;
   assign ready_c  = !vc_ff || ready_d;
   assign in_ready = ready_c;
   assign vc_in    = ready_c ? in_valid : vc_ff;
   assign vd_in    = ready_d ? vc_ff : vd_ff;
   assign ve_in    = ready_e ? vd_ff : ve_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         vc_ff <= vc_in;
         vd_ff <= vd_in;
         ve_ff <= ve_in;
      end
   end

   // pair_ff[2r] = columns 0,1 of row r; pair_ff[2r+1] = columns 2,3
   always_ff @(posedge clock) begin
      if (ready_c && in_valid) begin
         for (int r = 0; r < VEC_N; r++) begin
            pair_ff[2*r]   <= pair_type'(prod[r]) + pair_type'(prod[VEC_N + r]);
            pair_ff[2*r+1] <= pair_type'(prod[2*VEC_N + r]) + pair_type'(prod[3*VEC_N + r]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_d && vc_ff) begin
         for (int r = 0; r < VEC_N; r++) begin
            sum_ff[r] <= sum_type'(pair_ff[2*r]) + sum_type'(pair_ff[2*r+1]);
         end
      end
   end

   // Exact sum shifted right arithmetically = floor; clip to 32 bits.
   always_comb begin
      sum_type                 sh;
      logic [SUM_W-DATA_W:0]   top;
      sat_in = 1'b0;
      for (int r = 0; r < VEC_N; r++) begin
         sh  = sum_ff[r] >>> FRAC_BITS;
         top = sh[SUM_W-1:DATA_W-1];
         if (top != '0 && top != '1) begin
            sat_in    = 1'b1;
            res_in[r] = sh[SUM_W-1] ? WORD_MIN : WORD_MAX;
         end else begin
            res_in[r] = sh[DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_e && vd_ff) begin
         for (int r = 0; r < VEC_N; r++) begin
            res_ff[r] <= res_in[r];
         end
         sat_ff <= sat_in;
      end
   end

   assign out_valid = ve_ff;
   assign sat       = sat_ff;

   always_comb begin
      for (int r = 0; r < VEC_N; r++) begin
         res[r] = res_ff[r];
      end
   end

endmodule

// ----- hdl/vertex_transform_4x4.sv -----
// Transforms one vector per clock when nothing stalls, by a 4x4 signed
// fixed-point matrix held in column-major registers (element address
// column*4+row, identity after reset). A func=0 item writes one element and
// is consumed when the input stage is ready; the vector rate is set by the
// 16 parallel 32x32 multipliers in the product stage. The path is five
// register stages: input, products, pair sums, row sums, floor shift and
// saturation. Each stage holds under back-pressure on its own, so the input
// side keeps taking items until the pipeline is full. An element write
// waits while a vector sits in the input stage unable to move.
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// 4x4 matrix times 4-vector, Q(32-FRAC_BITS).FRAC_BITS, saturating.
// ----------------------------------------------------------------------------
module vertex_transform_4x4 #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  vt_pkg::idx_type   req_elem_index,
   input  vt_pkg::word_type  req_elem_value,
   input  vt_pkg::word_type  req_vec_x,
   input  vt_pkg::word_type  req_vec_y,
   input  vt_pkg::word_type  req_vec_z,
   input  vt_pkg::word_type  req_vec_w,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vt_pkg::word_type  rsp_res_x,
   output vt_pkg::word_type  rsp_res_y,
   output vt_pkg::word_type  rsp_res_z,
   output vt_pkg::word_type  rsp_res_w,
   output logic              rsp_saturated
);
   import vt_pkg::*;

   logic     mul_in_ready, mul_out_valid, red_in_ready;
   logic     wr_en;
   word_type mat [ELEM_N];
   word_type vec [VEC_N];
   prod_type prod [ELEM_N];
   word_type res [VEC_N];

   // Writes share the stall with vectors so matrix order follows item order.
   assign req_stall = !mul_in_ready;
   assign wr_en     = req_valid && mul_in_ready && (req_func == FUNC_WRITE);

   assign vec[0] = req_vec_x;
   assign vec[1] = req_vec_y;
   assign vec[2] = req_vec_z;
   assign vec[3] = req_vec_w;

   vt_matrix #(
      .FRAC_BITS (FRAC_BITS)
   ) u_matrix (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_index (req_elem_index),
      .wr_value (req_elem_value),
      .mat      (mat)
   );

   vt_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid && (req_func == FUNC_XFORM)),
      .in_ready  (mul_in_ready),
      .vec       (vec),
      .mat       (mat),
      .out_valid (mul_out_valid),
      .out_ready (red_in_ready),
      .prod      (prod)
   );

   vt_reduce #(
      .FRAC_BITS (FRAC_BITS)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_out_valid),
      .in_ready  (red_in_ready),
      .prod      (prod),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .res       (res),
      .sat       (rsp_saturated)
   );

   assign rsp_res_x = res[0];
   assign rsp_res_y = res[1];
   assign rsp_res_z = res[2];
   assign rsp_res_w = res[3];

endmodule

// ----- hdl/vt_checker.sv -----
// ----------------------------------------------------------------------------
// vt_checker
// Port-level checks on the vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vt_checker (
   input logic              clock,
   input logic              reset,
   input vt_pkg::word_type  rsp_res_x,
   input vt_pkg::word_type  rsp_res_y,
   input vt_pkg::word_type  rsp_res_z,
   input vt_pkg::word_type  rsp_res_w,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_saturated
);
   import vt_pkg::*;

   logic any_clip;

   assign any_clip = rsp_res_x == WORD_MAX || rsp_res_x == WORD_MIN ||
                     rsp_res_y == WORD_MAX || rsp_res_y == WORD_MIN ||
                     rsp_res_z == WORD_MAX || rsp_res_z == WORD_MIN ||
                     rsp_res_w == WORD_MAX || rsp_res_w == WORD_MIN;

   property p_rsp_hold;
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_res_x) && $stable(rsp_res_y)
         && $stable(rsp_res_z) && $stable(rsp_res_w) && $stable(rsp_saturated);
   endproperty

   property p_min_latency;
      rsp_valid |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3)
         && !$past(reset, 4) && !$past(reset, 5);
   endproperty

   // a held result keeps its value
   `VT_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "result changed while stalled")

   // a clipped item must show a rail value somewhere
   `VT_ASSERT(a_sat_rail, clock, reset, rsp_valid && rsp_saturated |-> any_clip, "saturated without a clipped component")

   // five stages: no item can reach the output sooner after reset
   `VT_ASSERT(a_min_latency, clock, reset, p_min_latency, "result sooner than pipeline depth")

endmodule

bind vertex_transform_4x4 vt_checker u_vt_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_res_x     (rsp_res_x),
   .rsp_res_y     (rsp_res_y),
   .rsp_res_z     (rsp_res_z),
   .rsp_res_w     (rsp_res_w),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_saturated (rsp_saturated)
);
